FILE: src/ipv4mhf_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter package
// Shared widths, fragment record, per-hop limits and register indexes.
// ----------------------------------------------------------------------------
package ipv4mhf_pkg;

  localparam int unsigned LenW  = 14;
  localparam int unsigned OffW  = 11;
  localparam int unsigned HopsW = 2;

  typedef logic [LenW-1:0] len_t;
  typedef logic [OffW-1:0] off_t;

  localparam len_t HEADER_BYTES     = len_t'(20);
  localparam len_t MTU_MIN          = len_t'(576);
  localparam len_t MTU_MAX          = len_t'(9000);
  localparam len_t MAX_PACKET_BYTES = len_t'(9000);

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    RegHops      = 2'd0,
    RegMtuFirst  = 2'd1,
    RegMtuSecond = 2'd2,
    RegMtuThird  = 2'd3
  } cfg_reg_e;

  // One fragment in flight: data bytes, offset in 8-byte units, end of run
  typedef struct packed {
    len_t data_len;
    off_t offset8;
    logic last;
  } frag_t;

  // Limits that one hop applies
  typedef struct packed {
    logic enable;
    len_t max_data;
    off_t piece8;
  } hop_cfg_t;

  // Clamp the MTU, then derive the largest payload and the 8-byte piece size
  function automatic hop_cfg_t hop_limits(len_t mtu, logic enable);
    hop_cfg_t cfg;
    len_t     clamped;
    len_t     max_data;
    clamped = mtu;
    if (mtu < MTU_MIN) begin
      clamped = MTU_MIN;
    end else if (mtu > MTU_MAX) begin
      clamped = MTU_MAX;
    end
    max_data     = clamped - HEADER_BYTES;
    cfg.enable   = enable;
    cfg.max_data = max_data;
    cfg.piece8   = max_data[LenW-1:3];
    return cfg;
  endfunction

endpackage

FILE: src/ipv4mhf_ingress.sv
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter ingress stage
// Clamps the packet length, strips the header and registers one whole-packet
// fragment for the first hop.
// ----------------------------------------------------------------------------
module ipv4mhf_ingress (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ipv4mhf_pkg::len_t   in_len_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipv4mhf_pkg::frag_t  out_frag_o
);
  import ipv4mhf_pkg::*;

  logic  valid_q, valid_d;
  frag_t frag_q;
  frag_t frag_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // Clamp into header-only .. maximum packet, keep data bytes only
  always_comb begin
    frag_d.offset8 = '0;
    frag_d.last    = 1'b1;
    if (in_len_i < HEADER_BYTES) begin
      frag_d.data_len = '0;
    end else if (in_len_i > MAX_PACKET_BYTES) begin
      frag_d.data_len = MAX_PACKET_BYTES - HEADER_BYTES;
    end else begin
      frag_d.data_len = in_len_i - HEADER_BYTES;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frag_q <= frag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_frag_o  = frag_q;

endmodule

FILE: src/ipv4mhf_hop_stage.sv
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter hop stage
// Applies one hop's MTU: a fragment that fits passes, a larger one is cut
// into full pieces, one per cycle unless output stalls, then the remainder.
// ----------------------------------------------------------------------------
module ipv4mhf_hop_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ipv4mhf_pkg::hop_cfg_t  cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ipv4mhf_pkg::frag_t     in_frag_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ipv4mhf_pkg::frag_t     out_frag_o
);
  import ipv4mhf_pkg::*;

  // Work register: the fragment still being cut
  logic  work_valid_q, work_valid_d;
  frag_t work_q, work_d;
  // Output register: the piece offered downstream
  logic  out_valid_q, out_valid_d;
  frag_t out_q, out_d;

  logic  out_free;
  logic  emit;
  logic  split;
  logic  done;
  len_t  piece_bytes;

  assign piece_bytes = {cfg_i.piece8, 3'b000};
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = work_valid_q && out_free;
  assign split       = cfg_i.enable && (work_q.data_len > cfg_i.max_data);
  assign done        = emit && !split;
  assign in_ready_o  = !work_valid_q || done;

  // Advance the work fragment: load, cut a piece off, or retire it
  always_comb begin
    work_valid_d = work_valid_q;
    work_d       = work_q;
    if (in_valid_i && in_ready_o) begin
      work_valid_d = 1'b1;
      work_d       = in_frag_i;
    end else if (emit && split) begin
      work_d.data_len = work_q.data_len - piece_bytes;
      work_d.offset8  = work_q.offset8 + cfg_i.piece8;
    end else if (done) begin
      work_valid_d = 1'b0;
    end
  end

  // Emit a full piece or the remainder, which inherits the end-of-run flag
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (split) begin
        out_d.data_len = piece_bytes;
        out_d.offset8  = work_q.offset8;
        out_d.last     = 1'b0;
      end else begin
        out_d = work_q;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_frag_o  = out_q;

endmodule

FILE: src/ipv4_multi_hop_fragmenter_core.sv
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter core
// Splits one packet length along a path of up to HOPS configured MTUs and
// streams out the fragments of the final hop in order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer when                  Carries
//  s_axis    in         s_axis_tvalid & s_axis_tready  packet_length
//  m_axis    out        m_axis_tvalid & m_axis_tready  frag_length, frag_offset,
//                                                      last_fragment (tlast)
//  cfg       in         cfg_valid_i & cfg_ready_o      register index, value
//
//  The last hop stage emits one fragment of the final hop per cycle unless
//  m_axis stalls. From an input transfer, the first fragment passes the
//  ingress register and then the work and output registers of each hop
//  stage in turn.
//  Reset clears all valid bits and loads hops 3 and MTUs of 1500 bytes.
//  A stall on m_axis holds every stage in place; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ipv4_multi_hop_fragmenter_core #(
  parameter int unsigned HOPS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // packet_length [13:0]
  input  logic [15:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // frag_length [13:0], frag_offset [24:14]
  output logic [31:0]                m_axis_tdata,
  output logic                       m_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  ipv4mhf_pkg::cfg_reg_e      cfg_index_i,
  input  ipv4mhf_pkg::len_t          cfg_data_i
);
  import ipv4mhf_pkg::*;

  logic [HopsW-1:0] hops_q;
  len_t             mtu_q [3];

  logic     stg_valid [HOPS+1];
  logic     stg_ready [HOPS+1];
  frag_t    stg_frag  [HOPS+1];
  hop_cfg_t hop_cfg   [HOPS];
  len_t     out_len;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hops_q   <= HopsW'(3);
      mtu_q[0] <= len_t'(1500);
      mtu_q[1] <= len_t'(1500);
      mtu_q[2] <= len_t'(1500);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHops:      hops_q   <= cfg_data_i[HopsW-1:0];
        RegMtuFirst:  mtu_q[0] <= cfg_data_i;
        RegMtuSecond: mtu_q[1] <= cfg_data_i;
        RegMtuThird:  mtu_q[2] <= cfg_data_i;
        default:      hops_q   <= hops_q;
      endcase
    end
  end

  // Header strip and clamp
  ipv4mhf_ingress u_ingress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_len_i    (s_axis_tdata[LenW-1:0]),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_frag_o  (stg_frag[0])
  );

  // One stage per hop; a hop beyond hops_q passes fragments unchanged
  for (genvar h = 0; h < HOPS; h++) begin : g_hop
    assign hop_cfg[h] = hop_limits(mtu_q[h], hops_q > HopsW'(h));

    ipv4mhf_hop_stage u_hop (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (hop_cfg[h]),
      .in_valid_i  (stg_valid[h]),
      .in_ready_o  (stg_ready[h]),
      .in_frag_i   (stg_frag[h]),
      .out_valid_o (stg_valid[h+1]),
      .out_ready_i (stg_ready[h+1]),
      .out_frag_o  (stg_frag[h+1])
    );
  end

  // Put the header back on and pack the result
  assign stg_ready[HOPS] = m_axis_tready;
  assign out_len         = stg_frag[HOPS].data_len + HEADER_BYTES;
  assign m_axis_tvalid   = stg_valid[HOPS];
  assign m_axis_tlast    = stg_frag[HOPS].last;
  assign m_axis_tdata    = {7'b0, stg_frag[HOPS].offset8, out_len};

endmodule

FILE: src/ipv4mhf_checker.sv
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter port checker
// Watches the result stream for stall behaviour and fragment sanity.
// ----------------------------------------------------------------------------
module ipv4mhf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // Hold a stalled result transfer
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Every fragment but the final one carries a multiple of 8 data bytes
  a_piece_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == 3'd4)
    else $error("non-final fragment data not 8-byte aligned");

  // Fragment length within header-only .. maximum packet
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:0] >= 14'd20 && m_axis_tdata[13:0] <= 14'd9000)
    else $error("fragment length out of range");

  // Offset stays within the largest packet and padding stays clear
  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24:14] <= 11'd1122 && m_axis_tdata[31:25] == 7'd0)
    else $error("fragment offset out of range");

endmodule

bind ipv4_multi_hop_fragmenter_core ipv4mhf_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

FILE: test/ipv4_multi_hop_fragmenter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 multi-hop fragmenter core testbench
// Feeds packet lengths over the input stream under several path settings,
// predicts the fragments of the last hop and checks every fragment transfer
// in order, with random idling on both streams.
// ----------------------------------------------------------------------------
module ipv4_multi_hop_fragmenter_core_tb;
  import ipv4mhf_pkg::*;

  localparam int unsigned MaxFrags   = 49;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumRows    = 30;

  // Expected fragment as it leaves the core
  typedef struct packed {
    len_t flen;
    off_t foff;
    logic flast;
  } frag_exp_t;

  // One directed step: a register write or a packet, the latter with an
  // optional single fragment typed in by hand
  typedef struct packed {
    logic     is_cfg;
    cfg_reg_e idx;
    len_t     value;
    logic     typed;
    len_t     t_len;
    off_t     t_off;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni        = 1'b0;
  logic     [15:0] s_axis_tdata = '0;
  logic     s_axis_tvalid = 1'b0;
  logic     s_axis_tready;
  logic     [31:0] m_axis_tdata;
  logic     m_axis_tlast;
  logic     m_axis_tvalid;
  logic     m_axis_tready = 1'b0;
  logic     cfg_valid_i   = 1'b0;
  logic     cfg_ready_o;
  cfg_reg_e cfg_index_i   = RegHops;
  len_t     cfg_data_i    = '0;

  // Path settings as the core should hold them
  logic [1:0] path_hops = 2'd3;
  len_t       path_mtu [3] = '{len_t'(1500), len_t'(1500), len_t'(1500)};

  frag_exp_t   expected_frags [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned dst_idle_pct   = 0;

  //                 cfg   index         value        typed len           off
  dir_row_t directed_rows [NumRows] = '{
    '{1'b0, RegHops,      14'd0,      1'b1, 14'd20,   11'd0}, // empty packet
    '{1'b0, RegHops,      14'd19,     1'b1, 14'd20,   11'd0}, // short packet
    '{1'b0, RegHops,      14'd20,     1'b1, 14'd20,   11'd0}, // bare header
    '{1'b0, RegHops,      14'd21,     1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd1500,   1'b1, 14'd1500, 11'd0}, // exactly fits
    '{1'b0, RegHops,      14'd1501,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd9000,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd16383,  1'b0, 14'd0,    11'd0}, // long packet
    '{1'b1, RegHops,      14'h3FFC,   1'b0, 14'd0,    11'd0}, // no hops
    '{1'b0, RegHops,      14'd16383,  1'b1, 14'd9000, 11'd0},
    '{1'b0, RegHops,      14'd5,      1'b1, 14'd20,   11'd0},
    '{1'b1, RegHops,      14'd1,      1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuFirst,  14'd0,      1'b0, 14'd0,    11'd0}, // MTU below range
    '{1'b0, RegHops,      14'd9000,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd576,    1'b1, 14'd576,  11'd0},
    '{1'b0, RegHops,      14'd577,    1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuFirst,  14'd16383,  1'b0, 14'd0,    11'd0}, // MTU above range
    '{1'b0, RegHops,      14'd9000,   1'b1, 14'd9000, 11'd0},
    '{1'b1, RegHops,      14'd3,      1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuFirst,  14'd1000,   1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuSecond, 14'd600,    1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuThird,  14'd577,    1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd9000,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd1001,   1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuFirst,  14'd9000,   1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuSecond, 14'd576,    1'b0, 14'd0,    11'd0},
    '{1'b1, RegMtuThird,  14'd9000,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd8999,   1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd596,    1'b0, 14'd0,    11'd0},
    '{1'b0, RegHops,      14'd576,    1'b1, 14'd576,  11'd0}
  };

  ipv4_multi_hop_fragmenter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Split one packet hop by hop and queue the fragments of the last hop
  function automatic void predict_fragments(len_t plen);
    int unsigned cur_len [$];
    int unsigned cur_off [$];
    int unsigned nxt_len [$];
    int unsigned nxt_off [$];
    int unsigned pkt, mtu, max_data, piece, rem, off;
    int unsigned h, i;
    frag_exp_t   fe;
    pkt = 32'(plen);
    if (pkt < 20) begin
      pkt = 20;
    end else if (pkt > 9000) begin
      pkt = 9000;
    end
    cur_len.insert(cur_len.size(), pkt - 20);
    cur_off.insert(cur_off.size(), 0);
    for (h = 0; h < 32'(path_hops); h++) begin
      mtu = 32'(path_mtu[h]);
      if (mtu < 576) begin
        mtu = 576;
      end else if (mtu > 9000) begin
        mtu = 9000;
      end
      max_data = mtu - 20;
      piece    = max_data & ~32'd7;
      nxt_len.delete();
      nxt_off.delete();
      for (i = 0; i < cur_len.size(); i++) begin
        rem = cur_len[i];
        off = cur_off[i];
        // cut full pieces while the remainder still does not fit
        while (rem > max_data) begin
          if (nxt_len.size() < MaxFrags) begin
            nxt_len.insert(nxt_len.size(), piece);
            nxt_off.insert(nxt_off.size(), off);
          end
          off += piece;
          rem -= piece;
        end
        if (nxt_len.size() < MaxFrags) begin
          nxt_len.insert(nxt_len.size(), rem);
          nxt_off.insert(nxt_off.size(), off);
        end
      end
      cur_len = nxt_len;
      cur_off = nxt_off;
    end
    for (i = 0; i < cur_len.size(); i++) begin
      fe.flen  = len_t'(cur_len[i] + 20);
      fe.foff  = off_t'(cur_off[i] >> 3);
      fe.flast = (i == cur_len.size() - 1);
      expected_frags.insert(expected_frags.size(), fe);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Compare one fragment transfer with the oldest expectation
  task automatic check_fragment();
    frag_exp_t want;
    if (expected_frags.size() == 0) begin
      report_mismatch("fragment with nothing outstanding, length",
                      32'(m_axis_tdata[13:0]), 32'd0);
    end else begin
      want = expected_frags.pop_front();
      if (m_axis_tdata[13:0] !== want.flen) begin
        report_mismatch("frag_length", 32'(m_axis_tdata[13:0]), 32'(want.flen));
      end
      if (m_axis_tdata[24:14] !== want.foff) begin
        report_mismatch("frag_offset", 32'(m_axis_tdata[24:14]), 32'(want.foff));
      end
      if (m_axis_tlast !== want.flast) begin
        report_mismatch("last_fragment", 32'(m_axis_tlast), 32'(want.flast));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_fragment();
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[ipv4_multi_hop_fragmenter_core] ERROR");
        $finish;
      end
    end
  end

  // Present one packet length; valid stays high into the next packet
  // unless the sender idles
  task automatic send_packet(len_t plen, logic typed, len_t t_len, off_t t_off);
    frag_exp_t fe;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, plen};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed) begin
      fe.flen  = t_len;
      fe.foff  = t_off;
      fe.flast = 1'b1;
      expected_frags.insert(expected_frags.size(), fe);
    end else begin
      predict_fragments(plen);
    end
  endtask

  // Hold the sender until every outstanding fragment has arrived
  task automatic drain_fragments();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_frags.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, len_t value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegHops) begin
      path_hops = value[1:0];
    end else begin
      path_mtu[int'(idx) - 1] = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Favour the range edges and small MTUs, with some values outside the range
  function automatic len_t pick_mtu();
    case ($urandom_range(9)) inside
      0:       return len_t'(576);
      1:       return len_t'(9000);
      2:       return len_t'($urandom_range(575));
      3:       return len_t'($urandom_range(16383, 9001));
      [4:5]:   return len_t'($urandom_range(700, 576));
      default: return len_t'($urandom_range(9000, 576));
    endcase
  endfunction

  function automatic len_t pick_packet();
    case ($urandom_range(19))
      0:       return len_t'($urandom_range(19));
      1:       return len_t'($urandom_range(16383, 9001));
      2:       return len_t'(9000);
      3:       return len_t'($urandom_range(16383));
      default: return len_t'($urandom_range(9000, 20));
    endcase
  endfunction

  task automatic randomise_path();
    write_reg(RegHops, len_t'($urandom_range(16383)));
    write_reg(RegMtuFirst, pick_mtu());
    write_reg(RegMtuSecond, pick_mtu());
    write_reg(RegMtuThird, pick_mtu());
  endtask

  initial begin
    int unsigned r, p, k, n;
    src_idle_pct = 28;
    dst_idle_pct = 75;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed steps from the reset settings onwards
    for (r = 0; r < NumRows; r++) begin
      if (directed_rows[r].is_cfg) begin
        drain_fragments();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_packet(directed_rows[r].value, directed_rows[r].typed,
                    directed_rows[r].t_len, directed_rows[r].t_off);
      end
    end

    // Random packets: three idling profiles, three paths each
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 28;
          dst_idle_pct = 75;
        end
        1: begin
          src_idle_pct = 75;
          dst_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      for (k = 0; k < 3; k++) begin
        drain_fragments();
        randomise_path();
        for (n = 0; n < 39; n++) begin
          if (n == 20) begin
            drain_fragments();
          end
          send_packet(pick_packet(), 1'b0, '0, '0);
        end
      end
    end

    drain_fragments();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ipv4_multi_hop_fragmenter_core] OK");
    end else begin
      $display("[ipv4_multi_hop_fragmenter_core] ERROR");
    end
    $finish;
  end

endmodule
